@@ design/sral_pkg.sv @@
package sral_pkg;

	// field widths fixed by the request and result formats
	localparam int SIZE_W     = 20;
	localparam int LEN_W      = 21;
	localparam int POOL_W     = 20;
	localparam int HDR_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	// register reset values
	localparam logic [POOL_W-1:0] POOL_RESET   = POOL_W'(8192);
	localparam logic [HDR_W-1:0]  HEADER_RESET = HDR_W'(112);

	// size rounding to 8-byte granules
	localparam logic [LEN_W-1:0] ROUND_MASK = LEN_W'(7);
	localparam logic [LEN_W-1:0] ROUND_STEP = LEN_W'(8);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = CFG_IDX_W'(1);

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_NO_SLOT,
		STATUS_NO_MEMORY,
		STATUS_NOT_FOUND
	} status_t;

	// classified request at the head of the queue
	typedef struct packed {
		logic             valid;
		logic             kind;
		logic [LEN_W-1:0] size;
	} work_t;

endpackage

@@ design/sral_cmd_if.sv @@
interface sral_cmd_if #(
	parameter int ADDR_BITS = 20
);
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [sral_pkg::SIZE_W-1:0] request_bytes;
	logic [ADDR_BITS-1:0]        block_address;

	modport source (output valid, output kind, output request_bytes, output block_address,
		input ready);
	modport sink (input valid, input kind, input request_bytes, input block_address,
		output ready);
endinterface

@@ design/sral_rsp_if.sv @@
interface sral_rsp_if #(
	parameter int SLOT_COUNT = 8,
	parameter int ADDR_BITS  = 20
);
	localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic                  valid;
	logic                  ready;
	logic [ADDR_BITS-1:0]  granted_address;
	logic [SLOT_BITS-1:0]  slot_index;
	logic                  reused;
	sral_pkg::status_t     status;
	logic                  pool_released;

	modport source (output valid, output granted_address, output slot_index, output reused,
		output status, output pool_released, input ready);
	modport sink (input valid, input granted_address, input slot_index, input reused,
		input status, input pool_released, output ready);
endinterface

@@ design/sral_cfg_if.sv @@
interface sral_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sral_pkg::CFG_IDX_W-1:0]  index;
	logic [sral_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/sral_front.sv @@
module sral_front #(
	parameter int ADDR_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sral_cmd_if.sink             command,
	output sral_pkg::work_t      head,
	output logic [ADDR_BITS-1:0] head_addr,
	input  logic                 pop
);
	import sral_pkg::*;

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	logic [LEN_W-1:0]     q_size_q [Q_DEPTH];
	logic                 q_kind_q [Q_DEPTH];
	logic [ADDR_BITS-1:0] q_addr_q [Q_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	logic                 push;
	logic                 do_pop;
	logic [LEN_W-1:0]     raw_size;
	logic [LEN_W-1:0]     rounded_size;

	// round the size up to a whole granule
	assign raw_size     = LEN_W'(command.request_bytes);
	assign rounded_size = ((raw_size & ROUND_MASK) != '0) ?
		((raw_size + ROUND_STEP) & ~ROUND_MASK) : raw_size;

	assign command.ready = (count_q != CNT_W'(Q_DEPTH));
	assign push          = command.valid && command.ready;
	assign do_pop        = pop && (count_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_size_q[wr_ptr_q] <= rounded_size;
			q_kind_q[wr_ptr_q] <= command.kind;
			q_addr_q[wr_ptr_q] <= command.block_address;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// head of queue toward the back end
	assign head.valid = (count_q != '0);
	assign head.kind  = q_kind_q[rd_ptr_q];
	assign head.size  = q_size_q[rd_ptr_q];
	assign head_addr  = q_addr_q[rd_ptr_q];

endmodule

@@ design/sral_back.sv @@
module sral_back #(
	parameter int SLOT_COUNT = 8,
	parameter int ADDR_BITS  = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sral_pkg::POOL_W-1:0]   pool_bytes,
	input  logic [sral_pkg::HDR_W-1:0]    header_bytes,
	input  sral_pkg::work_t               head,
	input  logic [ADDR_BITS-1:0]          head_addr,
	output logic                          pop,
	sral_rsp_if.source                    result
);
	import sral_pkg::*;

	localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LIVE_W    = $clog2(SLOT_COUNT + 1);
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]            state_q;
	logic [SLOT_BITS-1:0]  idx_q;

	// request being worked on
	logic                  kind_q;
	logic [LEN_W-1:0]      size_q;
	logic [ADDR_BITS-1:0]  addr_q;

	// scan findings
	logic                  first_found_q;
	logic [SLOT_BITS-1:0]  first_q;
	logic                  hit_found_q;
	logic [SLOT_BITS-1:0]  hit_q;
	logic [ADDR_BITS-1:0]  hit_offset_q;

	// slot table
	logic [SLOT_COUNT-1:0] busy_q;
	logic [SLOT_COUNT-1:0] assigned_q;
	logic [ADDR_BITS-1:0]  offset_q [SLOT_COUNT];
	logic [LEN_W-1:0]      length_q [SLOT_COUNT];
	logic [LEN_W-1:0]      hw_q;
	logic [LIVE_W-1:0]     live_q;

	// result register
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  out_addr_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic                  out_reused_q;
	status_t               out_status_q;
	logic                  out_released_q;

	logic                  slot_busy;
	logic                  slot_assigned;
	logic                  alloc_match;
	logic                  free_match;
	logic [LEN_W:0]        new_hw;
	logic [LEN_W:0]        end_hw;
	status_t               status;
	logic                  commit;
	logic                  last_live;

	// per-slot compare at the scan index
	assign slot_busy     = busy_q[idx_q];
	assign slot_assigned = assigned_q[idx_q];
	assign alloc_match   = !slot_busy && slot_assigned && (length_q[idx_q] == size_q);
	assign free_match    = slot_busy && slot_assigned && (offset_q[idx_q] == addr_q);

	// commit decision
	assign new_hw    = {1'b0, hw_q} + {1'b0, size_q};
	assign end_hw    = hit_found_q ? {1'b0, hw_q} : new_hw;
	assign last_live = (live_q == LIVE_W'(1));

	always_comb begin
		status = STATUS_OK;
		if (kind_q == KIND_ALLOC) begin
			priority if (!first_found_q)
				status = STATUS_NO_SLOT;
			else if (end_hw >= (LEN_W + 1)'(pool_bytes))
				status = STATUS_NO_MEMORY;
			else
				status = STATUS_OK;
		end else begin
			if (!hit_found_q)
				status = STATUS_NOT_FOUND;
		end
	end

	assign pop    = (state_q == ST_IDLE) && head.valid;
	assign commit = (state_q == ST_COMMIT) && (!out_valid_q || result.ready);

	// sequencer and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			first_found_q <= 1'b0;
			hit_found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						idx_q         <= '0;
						first_found_q <= 1'b0;
						hit_found_q   <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (kind_q == KIND_ALLOC) begin
						if (!slot_busy && !first_found_q)
							first_found_q <= 1'b1;
						if (alloc_match && !hit_found_q)
							hit_found_q <= 1'b1;
					end else if (free_match && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (idx_q == LAST_SLOT)
						state_q <= ST_COMMIT;
					else
						idx_q <= idx_q + SLOT_BITS'(1);
				end
				ST_COMMIT: begin
					if (commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request and finding payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			size_q <= head.size;
			addr_q <= head_addr;
		end
		if (state_q == ST_SCAN) begin
			if (kind_q == KIND_ALLOC) begin
				if (!slot_busy && !first_found_q)
					first_q <= idx_q;
				if (alloc_match && !hit_found_q) begin
					hit_q        <= idx_q;
					hit_offset_q <= offset_q[idx_q];
				end
			end else if (free_match && !hit_found_q) begin
				hit_q <= idx_q;
			end
		end
	end

	// slot flags, high-water mark and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			assigned_q <= '0;
			hw_q       <= LEN_W'(HEADER_RESET);
			live_q     <= '0;
		end else if (commit && (status == STATUS_OK)) begin
			if (kind_q == KIND_ALLOC) begin
				live_q <= live_q + LIVE_W'(1);
				if (hit_found_q) begin
					busy_q[hit_q] <= 1'b1;
				end else begin
					busy_q[first_q]     <= 1'b1;
					assigned_q[first_q] <= 1'b1;
					hw_q                <= new_hw[LEN_W-1:0];
				end
			end else if (last_live) begin
				busy_q     <= '0;
				assigned_q <= '0;
				hw_q       <= LEN_W'(header_bytes);
				live_q     <= '0;
			end else begin
				busy_q[hit_q] <= 1'b0;
				live_q        <= live_q - LIVE_W'(1);
			end
		end
	end

	// block placement of a fresh allocation
	always_ff @(posedge clk) begin
		if (commit && (status == STATUS_OK) && (kind_q == KIND_ALLOC) && !hit_found_q) begin
			offset_q[first_q] <= ADDR_BITS'(hw_q);
			length_q[first_q] <= size_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q   <= status;
			out_addr_q     <= '0;
			out_slot_q     <= '0;
			out_reused_q   <= 1'b0;
			out_released_q <= 1'b0;
			if (status == STATUS_OK) begin
				if (kind_q == KIND_ALLOC) begin
					out_reused_q <= hit_found_q;
					out_slot_q   <= hit_found_q ? hit_q : first_q;
					out_addr_q   <= hit_found_q ? hit_offset_q : ADDR_BITS'(hw_q);
				end else begin
					out_slot_q     <= hit_q;
					out_released_q <= last_live;
				end
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.granted_address = out_addr_q;
	assign result.slot_index      = out_slot_q;
	assign result.reused          = out_reused_q;
	assign result.status          = out_status_q;
	assign result.pool_released   = out_released_q;

`ifndef NO_ASSERTIONS
	// a busy slot always holds a block
	a_busy_assigned: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & ~assigned_q) == '0)
		else $error("busy slot without a block");

	// live count tracks the busy slots
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) == live_q)
		else $error("live count out of step with busy slots");

	// a result only appears out of a commit
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_COMMIT)
		else $error("result raised outside commit");

	// a scan in flight runs on to commit and does not return to idle early
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (state_q == ST_SCAN) || (state_q == ST_COMMIT))
		else $error("scan left early");
`endif

endmodule

@@ design/slot_reuse_bump_allocator_top.sv @@
// slot reuse bump allocator: a request queue feeds a slot-scanning sequencer
// a taken request waits in the queue, is popped only while the sequencer is idle,
// runs the one-slot-a-cycle scan and commits once the result register is free
// a two-entry queue takes requests while the scan and a pending result wait
// reset: asynchronous active low; pool empty, high-water at the header reset,
// registers at their reset values, no result pending
module slot_reuse_bump_allocator_top #(
	parameter int SLOT_COUNT = 8,
	parameter int ADDR_BITS  = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	sral_cmd_if.sink   command,
	sral_rsp_if.source result,
	sral_cfg_if.sink   cfg
);
	import sral_pkg::*;

	logic [POOL_W-1:0]    pool_bytes_q;
	logic [HDR_W-1:0]     header_bytes_q;
	work_t                head;
	logic [ADDR_BITS-1:0] head_addr;
	logic                 pop;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_bytes_q   <= POOL_RESET;
			header_bytes_q <= HEADER_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_POOL_BYTES)
				pool_bytes_q <= cfg.data[POOL_W-1:0];
			else if (cfg.index == REG_HEADER_BYTES)
				header_bytes_q <= cfg.data[HDR_W-1:0];
		end
	end

	sral_front #(
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.head      (head),
		.head_addr (head_addr),
		.pop       (pop)
	);

	sral_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_BITS  (ADDR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pool_bytes   (pool_bytes_q),
		.header_bytes (header_bytes_q),
		.head         (head),
		.head_addr    (head_addr),
		.pop          (pop),
		.result       (result)
	);

endmodule

@@ bench/slot_reuse_bump_allocator_top_tb.sv @@
module slot_reuse_bump_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sral_pkg::*;

	localparam int SLOTS        = 8;
	localparam int ADDR_BITS    = 20;
	localparam int SLOT_W       = 3;
	localparam int DRAIN_CYCLES = SLOTS + 6;
	localparam int PHASE_ITEMS  = 150;
	localparam int REPORT_LIMIT = 10;

	// register index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

	// one result as seen on the response channel
	typedef struct packed {
		logic [ADDR_BITS-1:0] granted;
		logic [SLOT_W-1:0]    slot;
		logic                 reused;
		status_t              status;
		logic                 released;
	} grant_t;

	// allocator shadow state and the grants it predicts
	class grant_scoreboard;
		bit [POOL_W-1:0]    pool_bytes;
		bit [HDR_W-1:0]     header_bytes;
		bit                 busy [SLOTS];
		bit                 assigned [SLOTS];
		bit [ADDR_BITS-1:0] offset [SLOTS];
		bit [LEN_W-1:0]     length [SLOTS];
		bit [LEN_W-1:0]     high_water;
		int unsigned        live_count;
		grant_t             pending_grants [$];
		int                 mismatches;

		function new();
			pool_bytes   = POOL_RESET;
			header_bytes = HEADER_RESET;
			mismatches   = 0;
			clear_pool();
		endfunction

		function void clear_pool();
			for (int i = 0; i < SLOTS; i++) begin
				busy[i]     = 1'b0;
				assigned[i] = 1'b0;
				offset[i]   = '0;
				length[i]   = '0;
			end
			high_water = LEN_W'(header_bytes);
			live_count = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_POOL_BYTES)
				pool_bytes = data;
			else if (idx == REG_HEADER_BYTES)
				header_bytes = data[HDR_W-1:0];
		endfunction

		function int pending();
			return pending_grants.size();
		endfunction

		// work out the grant for an accepted request and queue it
		function void take_request(logic kind, logic [SIZE_W-1:0] bytes,
				logic [ADDR_BITS-1:0] addr);
			grant_t         want;
			logic [LEN_W-1:0] size;
			logic [LEN_W:0] next_hw;
			int             first;
			int             hit;
			int             i;
			want  = '0;
			first = -1;
			hit   = -1;
			if (kind == KIND_ALLOC) begin
				// round up to the 8-byte granule
				size = LEN_W'(bytes);
				if ((size & ROUND_MASK) != '0)
					size = (size + ROUND_STEP) & ~ROUND_MASK;
				for (i = 0; i < SLOTS; i++)
					if (first < 0 && !busy[i])
						first = i;
				if (first < 0) begin
					want.status = STATUS_NO_SLOT;
				end else begin
					// same-size idle block at or after the first free slot
					for (i = first; i < SLOTS; i++)
						if (hit < 0 && !busy[i] && assigned[i] && length[i] == size)
							hit = i;
					next_hw = (hit >= 0) ? {1'b0, high_water} : {1'b0, high_water} + {1'b0, size};
					if (next_hw >= (LEN_W+1)'(pool_bytes)) begin
						want.status = STATUS_NO_MEMORY;
					end else if (hit >= 0) begin
						busy[hit]    = 1'b1;
						live_count++;
						want.granted = offset[hit];
						want.slot    = SLOT_W'(hit);
						want.reused  = 1'b1;
					end else begin
						busy[first]     = 1'b1;
						assigned[first] = 1'b1;
						offset[first]   = high_water[ADDR_BITS-1:0];
						length[first]   = size;
						want.granted    = high_water[ADDR_BITS-1:0];
						want.slot       = SLOT_W'(first);
						high_water      = next_hw[LEN_W-1:0];
						live_count++;
					end
				end
			end else begin
				// lowest live slot holding this offset
				for (i = 0; i < SLOTS; i++)
					if (hit < 0 && assigned[i] && busy[i] && offset[i] == addr)
						hit = i;
				if (hit < 0) begin
					want.status = STATUS_NOT_FOUND;
				end else begin
					busy[hit] = 1'b0;
					want.slot = SLOT_W'(hit);
					if (live_count > 0)
						live_count--;
					if (live_count == 0) begin
						clear_pool();
						want.released = 1'b1;
					end
				end
			end
			pending_grants.push_back(want);
		endfunction

		// compare a delivered result with the oldest predicted grant
		function void check_result(grant_t got);
			grant_t want;
			if (pending_grants.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: unexpected result addr=%h slot=%0d reused=%0b status=%s rel=%0b",
						$time, got.granted, got.slot, got.reused, got.status.name(), got.released);
				mismatches++;
				return;
			end
			want = pending_grants.pop_front();
			if (got !== want) begin
				if (mismatches < REPORT_LIMIT) begin
					$display("%0t: result mismatch", $time);
					$display("  expected addr=%h slot=%0d reused=%0b status=%s rel=%0b",
						want.granted, want.slot, want.reused, want.status.name(), want.released);
					$display("  actual   addr=%h slot=%0d reused=%0b status=%s rel=%0b",
						got.granted, got.slot, got.reused, got.status.name(), got.released);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   draining;

	grant_scoreboard sb;

	sral_cmd_if #(.ADDR_BITS(ADDR_BITS)) cmd_bus ();
	sral_rsp_if #(.SLOT_COUNT(SLOTS), .ADDR_BITS(ADDR_BITS)) rsp_bus ();
	sral_cfg_if cfg_bus ();

	slot_reuse_bump_allocator_top #(
		.SLOT_COUNT(SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.command(cmd_bus),
		.result (rsp_bus),
		.cfg    (cfg_bus)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		rsp_bus.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			sb.check_result({rsp_bus.granted_address, rsp_bus.slot_index, rsp_bus.reused,
				rsp_bus.status, rsp_bus.pool_released});
	end

	// issue one request, with random sender gaps in front of it
	task automatic send_request(logic kind, logic [SIZE_W-1:0] bytes,
			logic [ADDR_BITS-1:0] addr);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		cmd_bus.valid         <= 1'b1;
		cmd_bus.kind          <= kind;
		cmd_bus.request_bytes <= bytes;
		cmd_bus.block_address <= addr;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		sb.take_request(kind, bytes, addr);
	endtask

	task automatic alloc_req(logic [SIZE_W-1:0] bytes);
		send_request(KIND_ALLOC, bytes, ADDR_BITS'($urandom));
	endtask

	task automatic free_req(logic [ADDR_BITS-1:0] addr);
		send_request(KIND_FREE, SIZE_W'($urandom), addr);
	endtask

	// stop sending and wait until every grant has come back
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		sb.write_register(idx, data);
	endtask

	// reprogram both registers while the block is idle
	task automatic program_registers(logic [CFG_DATA_W-1:0] pool, logic [CFG_DATA_W-1:0] hdr,
			bit spare);
		settle();
		cfg_write(REG_POOL_BYTES, pool);
		cfg_write(REG_HEADER_BYTES, hdr);
		if (spare)
			cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	// mostly well-formed alloc/free traffic, with stray and stale frees mixed in
	task automatic random_request();
		int                   r;
		int                   j;
		int                   k;
		int                   pick;
		int                   span;
		int                   free_pct;
		logic [SIZE_W-1:0]    bytes;
		logic [ADDR_BITS-1:0] addr;
		bytes = SIZE_W'($urandom);
		addr  = ADDR_BITS'($urandom);
		if (sb.live_count == 0)
			draining = 1'b0;
		else if (!draining && $urandom_range(0, 99) < 4)
			draining = 1'b1;
		free_pct = draining ? 90 : 10 + 10 * int'(sb.live_count);
		r = $urandom_range(0, 99);
		j = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 99) < free_pct) begin
			pick = -1;
			if (r < 85) begin
				for (k = 0; k < SLOTS; k++)
					if (pick < 0 && sb.busy[(j + k) % SLOTS])
						pick = (j + k) % SLOTS;
				if (pick >= 0)
					addr = sb.offset[pick];
			end else if (r < 93) begin
				// stale offset, often a double free
				if (sb.assigned[j])
					addr = sb.offset[j];
			end
			send_request(KIND_FREE, bytes, addr);
		end else begin
			span = int'(sb.pool_bytes) / 6 + 16;
			if (r < 45) begin
				bytes = SIZE_W'($urandom_range(0, 40));
			end else if (r < 75) begin
				// aim at the size of an existing block
				if (sb.assigned[j] && sb.length[j] >= 8)
					bytes = SIZE_W'(sb.length[j] - $urandom_range(0, 7));
				else if (sb.assigned[j])
					bytes = '0;
				else
					bytes = SIZE_W'($urandom_range(0, 24));
			end else if (r < 92) begin
				bytes = SIZE_W'($urandom_range(0, span));
			end
			send_request(KIND_ALLOC, bytes, addr);
		end
	endtask

	// main sequence
	initial begin
		sb                    = new();
		arst_n                = 1'b0;
		cmd_bus.valid         = 1'b0;
		cmd_bus.kind          = KIND_ALLOC;
		cmd_bus.request_bytes = '0;
		cmd_bus.block_address = '0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = '0;
		cfg_bus.data          = '0;
		rsp_bus.ready         = 1'b0;
		send_idle_pct         = 19;
		recv_idle_pct         = 46;
		draining              = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset register values
		free_req(20'd0);           // never-assigned slot does not match
		alloc_req(20'd0);          // zero-size block on a fresh slot
		alloc_req(20'd1);          // rounds up to 8
		alloc_req(20'd8);
		alloc_req(20'hFFFFF);      // out of memory
		free_req(20'd112);         // lowest slot with the shared offset
		free_req(20'd112);
		free_req(20'd112);         // double free
		alloc_req(20'd0);          // reuse of the zero-size block
		alloc_req(20'd5);          // reuse of the 8-byte block
		repeat (5) alloc_req(20'd16);
		alloc_req(20'd16);         // every slot busy
		free_req(20'hFFFFF);       // address never handed out
		free_req(20'd112);
		free_req(20'd112);
		free_req(20'd120);
		free_req(20'd128);
		free_req(20'd144);
		free_req(20'd160);
		free_req(20'd176);
		free_req(20'd192);         // last live block releases the pool

		// random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: program_registers(20'hFFFFF, 20'h00000, 1'b0);
				1: program_registers(20'd512, 20'd40, 1'b1);
				2: program_registers(20'd0, 20'hFFFFF, 1'b0);
				3: program_registers(CFG_DATA_W'(POOL_RESET), CFG_DATA_W'(HEADER_RESET), 1'b0);
				4: program_registers(20'd600,
					{8'($urandom), 12'($urandom_range(0, 200))}, 1'b0);
				default: program_registers(20'($urandom_range(1024, 65535)),
					20'($urandom), 1'b0);
			endcase
			if (p < 2) begin
				send_idle_pct = 19;
				recv_idle_pct = 46;
			end else if (p < 4) begin
				send_idle_pct = 46;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (PHASE_ITEMS) random_request();
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
